/* sv/pip_pkg.sv */
// Shared types and constants of the even-odd point-in-polygon tester.
// No dependencies; used by pip_cell, pip_edge and the top level.
package pip_pkg;

   localparam int MAX_CORNERS_DEF = 64;
   localparam int COORD_BITS_DEF  = 16;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY  = 2'd2;

   // per-cell control: rotate from neighbor, or load an appended corner
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   // edge evaluator control: clear parity, present one edge
   typedef struct packed {
      logic clear;
      logic valid;
   } edge_ctl_type;

endpackage

/* sv/pip_cell.sv */
// One corner cell of the rotating corner ring.
// Depends on pip_pkg (cell_ctl_type).
module pip_cell #(
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  pip_pkg::cell_ctl_type        ctl,
   input  logic signed [COORD_BITS-1:0] nb_x,
   input  logic signed [COORD_BITS-1:0] nb_y,
   input  logic signed [COORD_BITS-1:0] ld_x,
   input  logic signed [COORD_BITS-1:0] ld_y,
   output logic signed [COORD_BITS-1:0] x,
   output logic signed [COORD_BITS-1:0] y
);

   logic signed [COORD_BITS-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         x_ff <= ld_x;
         y_ff <= ld_y;
      end else if (ctl.shift) begin
         x_ff <= nb_x;
         y_ff <= nb_y;
      end
   end

   assign x = x_ff;
   assign y = y_ff;

endmodule

/* sv/pip_edge.sv */
// Three-stage edge crossing evaluator with running even-odd parity.
// Depends on pip_pkg (edge_ctl_type).
module pip_edge #(
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pip_pkg::edge_ctl_type        ctl,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic signed [COORD_BITS-1:0] xj,
   input  logic signed [COORD_BITS-1:0] yj,
   input  logic signed [COORD_BITS-1:0] xi,
   input  logic signed [COORD_BITS-1:0] yi,
   output logic                         odd
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   // stage A: differences and side test
   logic                 a_valid_ff, a_valid_in;
   logic signed [DW-1:0] a_dxj_ff, a_dy_ff, a_ddy_ff, a_ddx_ff;
   // stage B: products
   logic                 b_valid_ff, b_valid_in;
   logic                 b_dpos_ff;
   logic signed [PW-1:0] b_lhs_ff, b_rhs_ff;
   logic                 odd_ff, odd_in;
   logic                 cur, prev, left;

   assign cur  = yi > py;
   assign prev = yj > py;
   assign a_valid_in = ctl.valid && (cur != prev);
   assign b_valid_in = a_valid_ff;
   assign left = b_dpos_ff ? (b_lhs_ff < b_rhs_ff) : (b_rhs_ff < b_lhs_ff);

   always_comb begin
      odd_in = odd_ff;
      if (ctl.clear) begin
         odd_in = 1'b0;
      end else if (b_valid_ff && left) begin
         odd_in = ~odd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         odd_ff     <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         odd_ff     <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      a_dxj_ff  <= DW'(xj) - DW'(xi);
      a_dy_ff   <= DW'(yj) - DW'(yi);
      a_ddy_ff  <= DW'(py) - DW'(yi);
      a_ddx_ff  <= DW'(px) - DW'(xi);
      b_lhs_ff  <= PW'(a_ddy_ff) * PW'(a_dxj_ff);
      b_rhs_ff  <= PW'(a_ddx_ff) * PW'(a_dy_ff);
      b_dpos_ff <= a_dy_ff > 0;
   end

   assign odd = odd_ff;

endmodule

/* sv/point_in_polygon_even_odd.sv */
// Top level of the even-odd point-in-polygon tester: control, corner ring,
// edge evaluator. Depends on pip_pkg, pip_cell and pip_edge.
//
// Usage:
//   req channel: one word per command. tuser selects clear, append or query;
//   tdata carries the corner or point coordinates. Clear empties the polygon
//   and drops the overflow flag; append stores the next corner (dropped and
//   flagged when all MAX_CORNERS cells are full); query tests a point.
//   rsp channel: one word per query, inside bit and sticky overflow bit.
// Timing:
//   clear and append are handled in the idle state. A query rotates the whole
//   corner ring past the evaluator, one corner per cycle, for any nonzero
//   corner count, then passes the close, drain and done states before
//   rsp_tvalid. A query on an empty polygon goes straight to the done state.
//   The next word is taken in the cycle the result appears. The evaluator
//   has three stages.
// Reset: synchronous, clears the corner count, overflow flag and rsp valid;
//   corner cells hold no reset value and are only read once written.
// Stall: a waiting result sits in the output register while clear and append
//   words are still taken; a query that finishes before that result is taken
//   holds in its final state until the register frees up.
module point_in_polygon_even_odd #(
   parameter int MAX_CORNERS = pip_pkg::MAX_CORNERS_DEF,
   parameter int COORD_BITS  = pip_pkg::COORD_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // fields from bit 0: coord_x, coord_y, zero fill
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]        req_tdata,
   // fields from bit 0: cmd
   input  logic [1:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // fields from bit 0: inside_res, overflowed, zero fill
   output logic [7:0]                               rsp_tdata
);

   localparam int CNT_W = $clog2(MAX_CORNERS + 1);
   localparam int IDX_W = $clog2(MAX_CORNERS);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_CLOSE  = 3'd2;
   localparam logic [2:0] ST_DRAIN0 = 3'd3;
   localparam logic [2:0] ST_DRAIN1 = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_inside_ff, rsp_ovf_ff;
   logic             rsp_load;

   logic signed [COORD_BITS-1:0] in_x, in_y;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic signed [COORD_BITS-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [COORD_BITS-1:0] edge_xi, edge_yi;

   logic signed [COORD_BITS-1:0] cell_x [MAX_CORNERS];
   logic signed [COORD_BITS-1:0] cell_y [MAX_CORNERS];

   logic                  req_fire, append_ok, scanning, idx_live, idx_last;
   pip_pkg::edge_ctl_type edge_ctl;
   logic                  odd;

   assign in_x     = req_tdata[COORD_BITS-1:0];
   assign in_y     = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire = req_tvalid && req_tready;
   assign append_ok = req_fire && (req_tuser == pip_pkg::CMD_APPEND)
                      && (count_ff < CNT_W'(MAX_CORNERS));
   assign scanning = (state_ff == ST_SCAN);
   assign idx_live = {{(CNT_W-IDX_W){1'b0}}, idx_ff} < count_ff;
   assign idx_last = idx_ff == IDX_W'(MAX_CORNERS - 1);
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_tready);

   // corner ring: each cell rotates from its upper neighbor while scanning
   for (genvar k = 0; k < MAX_CORNERS; k++) begin : g_cell
      localparam int NEXT = (k + 1) % MAX_CORNERS;
      pip_pkg::cell_ctl_type cctl;
      assign cctl.shift = scanning;
      assign cctl.load  = append_ok && (count_ff == CNT_W'(k));
      pip_cell #(.COORD_BITS(COORD_BITS)) u_cell (
         .clock (clock),
         .ctl   (cctl),
         .nb_x  (cell_x[NEXT]),
         .nb_y  (cell_y[NEXT]),
         .ld_x  (in_x),
         .ld_y  (in_y),
         .x     (cell_x[k]),
         .y     (cell_y[k])
      );
   end

   // edge selection: scan pairs (previous, current); close pairs (last, first)
   always_comb begin
      edge_ctl.clear = req_fire && (req_tuser == pip_pkg::CMD_QUERY);
      edge_ctl.valid = 1'b0;
      edge_xi = cell_x[0];
      edge_yi = cell_y[0];
      if (scanning) begin
         edge_ctl.valid = idx_live && (idx_ff != '0);
      end else if (state_ff == ST_CLOSE) begin
         edge_ctl.valid = 1'b1;
         edge_xi = first_x_ff;
         edge_yi = first_y_ff;
      end
   end

   pip_edge #(.COORD_BITS(COORD_BITS)) u_edge (
      .clock (clock),
      .reset (reset),
      .ctl   (edge_ctl),
      .px    (px_ff),
      .py    (py_ff),
      .xj    (prev_x_ff),
      .yj    (prev_y_ff),
      .xi    (edge_xi),
      .yi    (edge_yi),
      .odd   (odd)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_tuser)
                  pip_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                  end
                  pip_pkg::CMD_APPEND: begin
                     if (append_ok) begin
                        count_in = count_ff + 1'b1;
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  pip_pkg::CMD_QUERY: begin
                     idx_in   = '0;
                     state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
                  end
                  default: begin
                     // unused command: drop
                  end
               endcase
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 1'b1;
            if (idx_last) begin
               state_in = ST_CLOSE;
            end
         end
         ST_CLOSE:  state_in = ST_DRAIN0;
         ST_DRAIN0: state_in = ST_DRAIN1;
         ST_DRAIN1: state_in = ST_DONE;
         ST_DONE: begin
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: hold the point, track first and previous corner of the walk
   always_ff @(posedge clock) begin
      if (edge_ctl.clear) begin
         px_ff <= in_x;
         py_ff <= in_y;
      end
      if (scanning && idx_live) begin
         prev_x_ff <= cell_x[0];
         prev_y_ff <= cell_y[0];
         if (idx_ff == '0) begin
            first_x_ff <= cell_x[0];
            first_y_ff <= cell_y[0];
         end
      end
      if (rsp_load) begin
         rsp_inside_ff <= odd;
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_ovf_ff, rsp_inside_ff};

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_CORNERS))
      else $error("corner count beyond capacity");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside final state");

   a_query_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == pip_pkg::CMD_QUERY) && (count_ff != '0)
      |=> state_ff == ST_SCAN && idx_ff == '0)
      else $error("query with corners did not start a scan");
`endif

endmodule
